FILE: design/owb_pkg.sv
// Package for the 1-Wire bus master: register map, command and status codes,
// result record type and small helpers. No dependencies.
`default_nettype none
package owb_pkg;

	// Configuration register file
	localparam int NUM_REGS = 8;
	localparam int REG_W    = 10;
	localparam int IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_RESET_TAIL   = 3'd2;
	localparam logic [IDX_W-1:0] REG_WR_ONE_LOW   = 3'd3;
	localparam logic [IDX_W-1:0] REG_WR_ZERO_LOW  = 3'd4;
	localparam logic [IDX_W-1:0] REG_WR_SLOT      = 3'd5;
	localparam logic [IDX_W-1:0] REG_RD_LOW       = 3'd6;
	localparam logic [IDX_W-1:0] REG_RD_SAMPLE    = 3'd7;

	localparam logic [REG_W-1:0] REG_RESET_VALS [NUM_REGS] = '{
		10'd700, 10'd75, 10'd700, 10'd15, 10'd60, 10'd62, 10'd3, 10'd15
	};

	// Default parameter values
	localparam int DEF_READ_RECOVERY    = 75;
	localparam int DEF_TICK_COUNT_WIDTH = 10;

	// Command codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_RESET    = 3'd1;
	localparam logic [2:0] OP_WR_BYTE  = 3'd2;
	localparam logic [2:0] OP_RD_BYTE  = 3'd3;
	localparam logic [2:0] OP_RD_BIT   = 3'd4;

	// Reset outcome codes
	localparam logic [1:0] ST_PRESENT  = 2'd0;
	localparam logic [1:0] ST_NO_PRES  = 2'd1;
	localparam logic [1:0] ST_SHORTED  = 2'd2;

	// One result record per tick
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic [1:0] reset_status;
		logic       rejected;
	} owb_res_t;

	// A zero length counts as one tick
	function automatic logic [REG_W-1:0] min1(input logic [REG_W-1:0] v);
		return (v == '0) ? REG_W'(1) : v;
	endfunction

	// Release time: slot length minus low time, at least one tick
	function automatic logic [REG_W-1:0] rel_len(input logic [REG_W-1:0] slot,
			input logic [REG_W-1:0] low);
		return (slot > low) ? (slot - low) : REG_W'(1);
	endfunction

endpackage
`default_nettype wire

FILE: design/one_wire_bus_master.sv
// 1-Wire bus master top level: timing sequencer, configuration registers and
// output skid buffer. Depends on owb_pkg.
//
// Usage: each transaction on the input channel (in_valid/in_ready) is one
// microsecond tick carrying op, byte_in and the sampled line_level. An op of
// reset, write byte, read byte or read bit starts a command when idle; while
// a command runs such ops are dropped and flagged in rejected. Every input
// transaction gives exactly one result transaction (out_valid/out_ready)
// with drive_low, busy_res, done_res, read_data, reset_status and rejected.
// Each result is computed combinationally from the sequencer state and the
// tick, then held in the result register. One tick is taken every cycle
// while in_ready is high. A one-entry skid register lets one more tick be
// accepted while a result waits; with both full, in_ready drops until the
// receiver takes a result. The configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) is always ready and should be written only while idle.
// Reset (arst_n low) returns the sequencer to idle, clears the status and
// loads the register defaults; no clearing pass is needed.
`default_nettype none
module one_wire_bus_master #(
	parameter int READ_RECOVERY    = owb_pkg::DEF_READ_RECOVERY,
	parameter int TICK_COUNT_WIDTH = owb_pkg::DEF_TICK_COUNT_WIDTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// tick input channel
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [2:0]                    op,
	input  wire  [7:0]                    byte_in,
	input  wire                           line_level,
	// result channel
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          drive_low,
	output logic                          busy_res,
	output logic                          done_res,
	output logic [7:0]                    read_data,
	output logic [1:0]                    reset_status,
	output logic                          rejected,
	// configuration channel
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [owb_pkg::IDX_W-1:0]     cfg_index,
	input  wire  [owb_pkg::REG_W-1:0]     cfg_data
);
	import owb_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH;
	localparam int LW = (TW > REG_W) ? TW : REG_W;
	localparam logic [LW-1:0] CNT_MAX = LW'((64'd1 << TW) - 64'd1);
	localparam logic [REG_W-1:0] REC_LEN = REG_W'(READ_RECOVERY);

	// Sequencer phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_RST_LOW = 3'd1;
	localparam logic [2:0] PH_RST_REL = 3'd2;
	localparam logic [2:0] PH_WR_LOW  = 3'd3;
	localparam logic [2:0] PH_WR_REL  = 3'd4;
	localparam logic [2:0] PH_RD_LOW  = 3'd5;
	localparam logic [2:0] PH_RD_WAIT = 3'd6;
	localparam logic [2:0] PH_RD_REC  = 3'd7;

	logic [REG_W-1:0] cfg_q [NUM_REGS];

	logic [2:0]    phase_q;
	logic [TW-1:0] tick_q;
	logic [2:0]    bit_q;
	logic          single_q;
	logic [7:0]    shift_q;
	logic [1:0]    status_q;

	logic          out_valid_q, skid_valid_q;
	owb_res_t      out_q, skid_q;

	logic          in_fire;
	logic          is_cmd, start;
	logic [2:0]    ph, phase_nx;
	logic [TW-1:0] tc, tick_inc, tick_nx;
	logic [2:0]    bi, bit_nx;
	logic          sm;
	logic [7:0]    sb, shift_nx;
	logic [1:0]    status_nx;
	logic [REG_W-1:0] wr_low, len;
	logic [LW-1:0] fit, n_ext;
	logic          ends;
	owb_res_t      res;

	// Configuration register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET_VALS[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Command start and counter length selection
	assign in_fire = in_valid && in_ready;
	assign is_cmd  = (op == OP_RESET) || (op == OP_WR_BYTE) ||
		(op == OP_RD_BYTE) || (op == OP_RD_BIT);
	assign start   = (phase_q == PH_IDLE) && is_cmd;

	always_comb begin
		ph = phase_q;
		if (start) begin
			case (op)
				OP_RESET:   ph = PH_RST_LOW;
				OP_WR_BYTE: ph = PH_WR_LOW;
				default:    ph = PH_RD_LOW;
			endcase
		end
		tc = start ? '0 : tick_q;
		bi = start ? 3'd0 : bit_q;
		sm = start ? (op == OP_RD_BIT) : single_q;
		sb = start ? ((op == OP_WR_BYTE) ? byte_in : 8'd0) : shift_q;

		wr_low = sb[0] ? min1(cfg_q[REG_WR_ONE_LOW]) : min1(cfg_q[REG_WR_ZERO_LOW]);

		case (ph)
			PH_RST_LOW: len = min1(cfg_q[REG_RESET_LOW]);
			PH_RST_REL: len = (bi == 3'd0) ? min1(cfg_q[REG_PRES_WAIT])
				: min1(cfg_q[REG_RESET_TAIL]);
			PH_WR_LOW:  len = wr_low;
			PH_WR_REL:  len = rel_len(cfg_q[REG_WR_SLOT], wr_low);
			PH_RD_LOW:  len = min1(cfg_q[REG_RD_LOW]);
			PH_RD_WAIT: len = rel_len(cfg_q[REG_RD_SAMPLE], min1(cfg_q[REG_RD_LOW]));
			PH_RD_REC:  len = min1(REC_LEN);
			default:    len = REG_W'(1);
		endcase

		// saturate at the counter maximum
		fit = (LW'(len) > CNT_MAX) ? CNT_MAX : LW'(len);
	end

	assign tick_inc = tc + TW'(1);
	assign n_ext    = LW'(tick_inc);
	assign ends     = (n_ext >= fit);

	// Sequencer next state and result
	always_comb begin
		phase_nx  = ph;
		tick_nx   = tc;
		bit_nx    = bi;
		shift_nx  = sb;
		status_nx = status_q;
		res       = '0;
		res.busy_res = (ph != PH_IDLE);
		res.rejected = (phase_q != PH_IDLE) && is_cmd;

		if (ph != PH_IDLE) begin
			tick_nx = ends ? '0 : tick_inc;
		end

		case (ph)
			PH_RST_LOW: begin
				res.drive_low = 1'b1;
				if (ends) begin
					phase_nx = PH_RST_REL;
					bit_nx   = 3'd0;
				end
			end
			PH_RST_REL: begin
				if (ends) begin
					if (bi == 3'd0) begin
						if (line_level) begin
							status_nx    = ST_NO_PRES;
							res.done_res = 1'b1;
						end else begin
							bit_nx = 3'd1;
						end
					end else begin
						status_nx    = line_level ? ST_PRESENT : ST_SHORTED;
						res.done_res = 1'b1;
					end
				end
			end
			PH_WR_LOW: begin
				res.drive_low = 1'b1;
				if (ends) begin
					phase_nx = PH_WR_REL;
				end
			end
			PH_WR_REL: begin
				if (ends) begin
					shift_nx = {1'b0, sb[7:1]};
					bit_nx   = bi + 3'd1;
					if (bi == 3'd7) begin
						res.done_res = 1'b1;
					end else begin
						phase_nx = PH_WR_LOW;
					end
				end
			end
			PH_RD_LOW: begin
				res.drive_low = 1'b1;
				if (ends) begin
					phase_nx = PH_RD_WAIT;
				end
			end
			PH_RD_WAIT: begin
				if (ends) begin
					shift_nx = sm ? {7'd0, line_level} : {line_level, sb[7:1]};
					phase_nx = PH_RD_REC;
				end
			end
			PH_RD_REC: begin
				if (ends) begin
					if (sm) begin
						res.read_data = {7'd0, sb[0]};
						res.done_res  = 1'b1;
					end else begin
						bit_nx = bi + 3'd1;
						if (bi == 3'd7) begin
							res.read_data = sb;
							res.done_res  = 1'b1;
						end else begin
							phase_nx = PH_RD_LOW;
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (res.done_res) begin
			phase_nx = PH_IDLE;
			tick_nx  = '0;
			bit_nx   = 3'd0;
		end
		res.reset_status = status_nx;
	end

	// Sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bit_q    <= 3'd0;
			single_q <= 1'b0;
			shift_q  <= 8'd0;
			status_q <= ST_PRESENT;
		end else if (in_fire) begin
			phase_q  <= phase_nx;
			tick_q   <= tick_nx;
			bit_q    <= bit_nx;
			single_q <= sm;
			shift_q  <= shift_nx;
			status_q <= status_nx;
		end
	end

	// Result register with one skid entry
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_ready) begin
				out_valid_q  <= in_fire || skid_valid_q;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (in_fire && out_valid_q && !out_ready) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_low    = out_q.drive_low;
	assign busy_res     = out_q.busy_res;
	assign done_res     = out_q.done_res;
	assign read_data    = out_q.read_data;
	assign reset_status = out_q.reset_status;
	assign rejected     = out_q.rejected;

endmodule
`default_nettype wire
